// ----- hw/rtl/spi_baud_divider_search_unit_macros.svh -----
// Assertion macros shared by the serial clock divider search RTL.
`ifndef SPI_BAUD_DIVIDER_SEARCH_UNIT_MACROS_SVH
`define SPI_BAUD_DIVIDER_SEARCH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property at every rising edge outside reset.
`define SBDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SBDS_ASSERT(lbl, prop, msg)
`define SBDS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/sbds_pkg.sv -----
// Package with the constants, tables and interface types of the divider search.
`default_nettype none

package sbds_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned ScalerW  = 4;
  localparam int unsigned PreW     = 2;
  localparam int unsigned CandW    = ScalerW + PreW;
  localparam int unsigned NumCand  = 1 << CandW;
  localparam int unsigned DivW     = 18;
  localparam int unsigned StepW    = 5;
  localparam int unsigned DivSteps = DataW;

  localparam logic [DataW-1:0] ClkHzReset = 32'd50000000;
  localparam logic [CandW-1:0] LastCand   = CandW'(NumCand - 1);
  localparam logic [StepW-1:0] LastStep   = StepW'(DivSteps - 1);

  localparam logic [15:0] ScalerTab [16] = '{
    16'd2, 16'd4, 16'd6, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128,
    16'd256, 16'd512, 16'd1024, 16'd2048, 16'd4096, 16'd8192, 16'd16384, 16'd32768
  };

  localparam logic [2:0] PrescalerTab [4] = '{3'd2, 3'd3, 3'd5, 3'd7};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             capture;
    logic             load;
    logic             step;
    logic             eval;
    logic [CandW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

  // Total divisor of one candidate: scaler entry times prescaler entry.
  function automatic logic [DivW-1:0] cand_divisor(input logic [CandW-1:0] idx);
    logic [DivW-1:0] scl;
    logic [DivW-1:0] pre;
    scl = DivW'(ScalerTab[idx[CandW-1:PreW]]);
    pre = DivW'(PrescalerTab[idx[PreW-1:0]]);
    return scl * pre;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/spi_baud_divider_search_unit.sv -----
// Top level of the serial clock divider search: controller and datapath.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | to block  | in_valid_i / in_stall_o    | desired_baud_i
//   out     | from block| out_valid_o / out_stall_i  | scaler_index_o, prescaler_index_o,
//           |           |                            | achieved_baud_o, exact_match_o,
//           |           |                            | above_target_o
//   cfg     | to block  | cfg_we_i                   | cfg_wdata_i (module clock in hertz)
//
// Each candidate is loaded as a divisor, run through the restoring serial divider
// (one quotient bit per cycle) and then compared against the best so far.
// A beat visits 1 to 64 candidates, one after another on the shared serial divider.
// One beat is worked on at a time: in_stall_o is high from acceptance until the result
// beat has been taken, and the result holds steady while out_stall_i is high.
// Reset returns the controller to idle and loads the module clock register with 50 MHz.
`default_nettype none

module spi_baud_divider_search_unit
  import sbds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DataW-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [DataW-1:0] desired_baud_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ScalerW-1:0]    scaler_index_o,
  output logic [PreW-1:0]       prescaler_index_o,
  output logic [DataW-1:0]      achieved_baud_o,
  output logic                  exact_match_o,
  output logic                  above_target_o
);

  // Commands from the controller and the exact-hit status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller walks the candidates in table order, scaler index outer.
  sbds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath divides the module clock by each candidate's divisor and keeps the
  // first candidate with the strictly smallest error; its best registers are the result.
  sbds_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .desired_baud_i    (desired_baud_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .scaler_index_o    (scaler_index_o),
    .prescaler_index_o (prescaler_index_o),
    .achieved_baud_o   (achieved_baud_o),
    .exact_match_o     (exact_match_o),
    .above_target_o    (above_target_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/sbds_ctrl.sv -----
// Controller state machine that sequences the candidate walk and the serial divider.
`default_nettype none

`include "spi_baud_divider_search_unit_macros.svh"

module sbds_ctrl
  import sbds_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e           state_q, state_d;
  logic [CandW-1:0] idx_q, idx_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          idx_d         = '0;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.hit || (idx_q == LastCand)) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `SBDS_ASSERT_NEXT(a_hit_ends_search, cmd_o.eval && sts_i.hit, state_q == ST_DONE, "exact hit did not end the search")
  `SBDS_ASSERT_NEXT(a_idx_advances, cmd_o.eval && !sts_i.hit && (idx_q != LastCand), idx_q == $past(idx_q) + 1'b1, "candidate index did not advance")
  `SBDS_ASSERT(a_div_full_length, (state_q == ST_EVAL) |-> (step_q == '0), "divider left before all quotient bits")

endmodule

`default_nettype wire

// ----- hw/rtl/sbds_datapath.sv -----
// Datapath: clock register, restoring serial divider and best-candidate tracking.
`default_nettype none

`include "spi_baud_divider_search_unit_macros.svh"

module sbds_datapath
  import sbds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DataW-1:0] cfg_wdata_i,
  input  wire logic [DataW-1:0] desired_baud_i,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  output logic [ScalerW-1:0]    scaler_index_o,
  output logic [PreW-1:0]       prescaler_index_o,
  output logic [DataW-1:0]      achieved_baud_o,
  output logic                  exact_match_o,
  output logic                  above_target_o
);

  logic [DataW-1:0] clk_hz_q;
  logic [DataW-1:0] want_q;
  logic [DivW-1:0]  div_q;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic             have_q, exact_q;
  logic [DataW-1:0] best_err_q, best_rate_q;
  logic [CandW-1:0] best_idx_q;

  logic [DivW:0]    trial;
  logic [DivW:0]    diff;
  logic             ge;
  logic [DataW-1:0] err;
  logic             hit;
  logic             better;

  // One quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[DataW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
    quo_d = {quo_q[DataW-2:0], ge};
  end

  always_comb begin
    hit    = (quo_q == want_q);
    err    = (quo_q >= want_q) ? (quo_q - want_q) : (want_q - quo_q);
    better = !have_q || (err < best_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkHzReset;
      have_q   <= 1'b0;
      exact_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        clk_hz_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        have_q  <= 1'b0;
        exact_q <= 1'b0;
      end else if (cmd_i.eval) begin
        have_q <= 1'b1;
        if (hit) begin
          exact_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      want_q <= desired_baud_i;
    end
    if (cmd_i.load) begin
      div_q <= cand_divisor(cmd_i.idx);
      rem_q <= '0;
      quo_q <= clk_hz_q;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.eval && (hit || better)) begin
      best_err_q  <= err;
      best_rate_q <= quo_q;
      best_idx_q  <= cmd_i.idx;
    end
  end

  assign sts_o.hit         = hit;
  assign scaler_index_o    = best_idx_q[CandW-1:PreW];
  assign prescaler_index_o = best_idx_q[PreW-1:0];
  assign achieved_baud_o   = best_rate_q;
  assign exact_match_o     = exact_q;
  assign above_target_o    = !exact_q && (best_rate_q > want_q);

  `SBDS_ASSERT(a_exact_rate, exact_q |-> (best_rate_q == want_q), "exact flag without equal rate")
  `SBDS_ASSERT(a_divisor_nonzero, cmd_i.step |-> (div_q != '0), "serial divider runs with a zero divisor")
  `SBDS_ASSERT_NEXT(a_eval_sets_have, cmd_i.eval, have_q, "evaluated candidate not recorded as best")

endmodule

`default_nettype wire
